// File: hdl/sst_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the source tokenizer.
// Used by sst_scan, script_source_tokenizer and the testbench; depends on nothing else.
package sst_pkg;

    localparam int POS_W  = 24;
    localparam int LEN_W  = 16;
    localparam int LINE_W = 16;
    localparam int KIND_W = 5;
    localparam int QDEPTH = 4;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_EQ,
        MODE_BANG,
        MODE_LT,
        MODE_GT,
        MODE_AMP,
        MODE_PIPE,
        MODE_SLASH,
        MODE_COMMENT
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_END, KIND_IDENT, KIND_INT, KIND_PLUS, KIND_MINUS, KIND_STAR,
        KIND_SLASH, KIND_PERCENT, KIND_EQEQ, KIND_NE, KIND_LT, KIND_LE,
        KIND_GT, KIND_GE, KIND_ANDAND, KIND_OROR, KIND_BANG, KIND_ASSIGN,
        KIND_LPAREN, KIND_RPAREN, KIND_LBRACE, KIND_RBRACE, KIND_COMMA,
        KIND_SEMI, KIND_LET, KIND_IF, KIND_ELSE, KIND_WHILE, KIND_RETURN,
        KIND_FN
    } t_kind;

    typedef struct packed {
        t_mode              mode;
        logic [5:0]         kw_match;
        logic [POS_W-1:0]   p_start;
        logic [LEN_W-1:0]   p_len;
        logic [LINE_W-1:0]  p_line;
        logic [LINE_W-1:0]  cur_line;
        logic [POS_W-1:0]   pos;
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   start;
        logic [LEN_W-1:0]   length;
        logic [LINE_W-1:0]  line;
        logic               last;
    } t_token;

    // Keyword spellings, padded with zeros so a 3-bit index is always in range.
    localparam logic [7:0] KW_TEXT [6][8] = '{
        '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [6] = '{3'd3, 3'd2, 3'd4, 3'd5, 3'd6, 3'd2};

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [LINE_W-1:0] sat_line(input logic [LINE_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Keeps the keywords whose character at position idx equals c.
    function automatic logic [5:0] kw_update(input logic [5:0] mask,
                                             input logic [LEN_W-1:0] idx,
                                             input logic [7:0] c);
        logic [5:0] res;
        res = '0;
        for (int k = 0; k < 6; k++) begin
            if (mask[k] && idx < LEN_W'(KW_LEN[k]) && KW_TEXT[k][idx[2:0]] == c)
                res[k] = 1'b1;
        end
        return res;
    endfunction

    function automatic t_kind ident_kind(input logic [5:0] mask,
                                         input logic [LEN_W-1:0] len);
        t_kind kd;
        kd = KIND_IDENT;
        for (int k = 5; k >= 0; k--) begin
            if (mask[k] && len == LEN_W'(KW_LEN[k]))
                kd = t_kind'(KIND_W'(KIND_LET) + KIND_W'(k));
        end
        return kd;
    endfunction

endpackage

// File: hdl/sst_scan.sv
`timescale 1ns / 1ps
// Per-byte scanner step: from the held state and one byte it forms the next
// state and up to two tokens. Purely combinational; depends on sst_pkg.
module sst_scan (
    input  sst_pkg::t_state i_state,
    input  logic [7:0]      i_byte,
    output sst_pkg::t_state o_state,
    output sst_pkg::t_token o_tok0,
    output sst_pkg::t_token o_tok1,
    output logic [1:0]      o_count
);
    import sst_pkg::*;

    t_state ns;
    t_token held_tok;
    t_token new_tok;
    logic   held_v;
    logic   new_v;
    logic   done;
    logic   pair;
    logic [7:0] second;
    t_kind  two_kind;
    t_kind  one_kind;
    t_kind  single;
    t_mode  hold;

    always_comb begin
        ns       = i_state;
        held_v   = 1'b0;
        new_v    = 1'b0;
        done     = 1'b0;
        pair     = 1'b0;
        second   = "=";
        two_kind = KIND_EQEQ;
        one_kind = KIND_ASSIGN;
        single   = KIND_END;
        hold     = MODE_IDLE;
        held_tok = '{kind: KIND_END, start: i_state.p_start, length: i_state.p_len,
                     line: i_state.p_line, last: 1'b0};
        new_tok  = '{kind: KIND_END, start: i_state.pos, length: LEN_W'(1),
                     line: i_state.cur_line, last: 1'b0};

        // First settle the token held from earlier bytes.
        case (i_state.mode)
            MODE_IDENT: begin
                if (is_alpha(i_byte) || is_digit(i_byte) || i_byte == "_") begin
                    ns.kw_match = kw_update(i_state.kw_match, i_state.p_len, i_byte);
                    ns.p_len    = sat_len(i_state.p_len);
                    ns.pos      = sat_pos(i_state.pos);
                    done        = 1'b1;
                end else begin
                    held_v        = 1'b1;
                    held_tok.kind = ident_kind(i_state.kw_match, i_state.p_len);
                end
            end
            MODE_INT: begin
                if (is_digit(i_byte) || i_byte == "_") begin
                    ns.p_len = sat_len(i_state.p_len);
                    ns.pos   = sat_pos(i_state.pos);
                    done     = 1'b1;
                end else begin
                    held_v        = 1'b1;
                    held_tok.kind = KIND_INT;
                end
            end
            MODE_EQ: begin
                pair = 1'b1;
            end
            MODE_BANG: begin
                pair = 1'b1; two_kind = KIND_NE; one_kind = KIND_BANG;
            end
            MODE_LT: begin
                pair = 1'b1; two_kind = KIND_LE; one_kind = KIND_LT;
            end
            MODE_GT: begin
                pair = 1'b1; two_kind = KIND_GE; one_kind = KIND_GT;
            end
            MODE_AMP: begin
                pair = 1'b1; second = "&"; two_kind = KIND_ANDAND; one_kind = KIND_END;
            end
            MODE_PIPE: begin
                pair = 1'b1; second = "|"; two_kind = KIND_OROR; one_kind = KIND_END;
            end
            MODE_SLASH: begin
                if (i_byte == "/") begin
                    ns.mode = MODE_COMMENT;
                    ns.pos  = sat_pos(i_state.pos);
                    done    = 1'b1;
                end else begin
                    held_v          = 1'b1;
                    held_tok.kind   = KIND_SLASH;
                    held_tok.length = LEN_W'(1);
                end
            end
            MODE_COMMENT: begin
                if (i_byte != 8'h00) begin
                    if (i_byte == "\n") begin
                        ns.cur_line = sat_line(i_state.cur_line);
                        ns.mode     = MODE_IDLE;
                    end
                    ns.pos = sat_pos(i_state.pos);
                    done   = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (pair) begin
            held_v = 1'b1;
            if (i_byte == second) begin
                held_tok.kind   = two_kind;
                held_tok.length = LEN_W'(2);
                ns.mode         = MODE_IDLE;
                ns.pos          = sat_pos(i_state.pos);
                done            = 1'b1;
            end else begin
                held_tok.kind   = one_kind;
                held_tok.length = LEN_W'(1);
            end
        end

        // Then scan the byte itself.
        if (!done) begin
            ns.mode = MODE_IDLE;
            if (i_byte == 8'h00) begin
                new_v          = 1'b1;
                new_tok.length = '0;
                ns.pos         = '0;
                ns.cur_line    = LINE_W'(1);
                ns.p_start     = '0;
                ns.p_len       = '0;
                ns.p_line      = LINE_W'(1);
                ns.kw_match    = '0;
            end else begin
                if (i_byte inside {" ", "\t", "\r", "\n"}) begin
                    if (i_byte == "\n")
                        ns.cur_line = sat_line(i_state.cur_line);
                end else if (is_alpha(i_byte) || i_byte == "_") begin
                    ns.mode     = MODE_IDENT;
                    ns.p_start  = i_state.pos;
                    ns.p_len    = LEN_W'(1);
                    ns.p_line   = i_state.cur_line;
                    ns.kw_match = kw_update(6'h3F, '0, i_byte);
                end else if (is_digit(i_byte)) begin
                    ns.mode    = MODE_INT;
                    ns.p_start = i_state.pos;
                    ns.p_len   = LEN_W'(1);
                    ns.p_line  = i_state.cur_line;
                end else begin
                    case (i_byte)
                        "+":     single = KIND_PLUS;
                        "-":     single = KIND_MINUS;
                        "*":     single = KIND_STAR;
                        "%":     single = KIND_PERCENT;
                        "(":     single = KIND_LPAREN;
                        ")":     single = KIND_RPAREN;
                        "{":     single = KIND_LBRACE;
                        "}":     single = KIND_RBRACE;
                        ",":     single = KIND_COMMA;
                        ";":     single = KIND_SEMI;
                        "/":     hold = MODE_SLASH;
                        "=":     hold = MODE_EQ;
                        "!":     hold = MODE_BANG;
                        "<":     hold = MODE_LT;
                        ">":     hold = MODE_GT;
                        "&":     hold = MODE_AMP;
                        "|":     hold = MODE_PIPE;
                        default: single = KIND_END;
                    endcase
                    if (hold != MODE_IDLE) begin
                        ns.mode     = hold;
                        ns.p_start  = i_state.pos;
                        ns.p_len    = LEN_W'(1);
                        ns.p_line   = i_state.cur_line;
                        ns.kw_match = '0;
                    end else begin
                        new_v        = 1'b1;
                        new_tok.kind = single;
                    end
                end
                ns.pos = sat_pos(i_state.pos);
            end
        end
    end

    always_comb begin
        o_state = ns;
        o_count = {1'b0, held_v} + {1'b0, new_v};
        o_tok0  = held_v ? held_tok : new_tok;
        o_tok1  = new_tok;
        o_tok0.last = !(held_v && new_v);
        o_tok1.last = 1'b1;
    end

endmodule

// File: hdl/script_source_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the streaming source tokenizer: scanner state, byte handshake
// and token output queue. Depends on sst_pkg and sst_scan.
//
// The tokens a byte closes are written into the registered output queue at its transfer.
// Throughput: one byte per cycle while no byte yields two tokens and the output is
// not stalled; a byte yielding two tokens is absorbed by a four-entry queue.
// Reset (synchronous, active low) returns the scanner to line 1, offset 0, and
// empties the queue.
module script_source_tokenizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_text_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sst_pkg::KIND_W-1:0]  o_token_kind,
    output logic [sst_pkg::POS_W-1:0]   o_token_start,
    output logic [sst_pkg::LEN_W-1:0]   o_token_length,
    output logic [sst_pkg::LINE_W-1:0]  o_token_line,
    output logic                        o_run_last
);
    import sst_pkg::*;

    // Scanner state. It only moves on a byte transfer, so a stalled input
    // leaves any held identifier, number or operator untouched.
    t_state r_state;
    t_state n_state;

    // Token queue: entry 0 is always the head shown on the output ports.
    t_token r_q [QDEPTH];
    t_token n_q [QDEPTH];
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;

    t_token     tok0;
    t_token     tok1;
    logic [1:0] nres;
    logic       acc;
    logic       pop;
    logic [QCNT_W-1:0] base;

    sst_scan u_scan (
        .i_state (r_state),
        .i_byte  (i_text_byte),
        .o_state (n_state),
        .o_tok0  (tok0),
        .o_tok1  (tok1),
        .o_count (nres)
    );

    // A byte is taken whenever there is room for the two tokens it may close,
    // independent of whether the head is being taken in the same cycle.
    assign o_ready = r_cnt <= QCNT_W'(QDEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign acc     = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign base    = r_cnt - QCNT_W'(pop);

    always_comb begin
        n_cnt = base + (acc ? QCNT_W'(nres) : '0);
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && i < QDEPTH - 1)
                n_q[i] = r_q[i + 1];
            else
                n_q[i] = r_q[i];
            if (acc && nres != 2'd0 && base == QCNT_W'(i))
                n_q[i] = tok0;
            if (acc && nres == 2'd2 && base + 1'b1 == QCNT_W'(i))
                n_q[i] = tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode     <= MODE_IDLE;
            r_state.kw_match <= '0;
            r_state.p_start  <= '0;
            r_state.p_len    <= '0;
            r_state.p_line   <= LINE_W'(1);
            r_state.cur_line <= LINE_W'(1);
            r_state.pos      <= '0;
            r_cnt            <= '0;
        end else begin
            if (acc)
                r_state <= n_state;
            r_cnt <= n_cnt;
        end
    end

    // Queue payload carries no reset; the count says which entries are live.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++)
            r_q[i] <= n_q[i];
    end

    assign o_token_kind   = r_q[0].kind;
    assign o_token_start  = r_q[0].start;
    assign o_token_length = r_q[0].length;
    assign o_token_line   = r_q[0].line;
    assign o_run_last     = r_q[0].last;

    // The queue never overflows its four entries.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("token queue count exceeds depth");

    // Every token a byte produces lands in the queue.
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !pop |=> r_cnt == $past(r_cnt) + QCNT_W'($past(nres)))
        else $error("token queue count lost a push");

    // When a byte closes two tokens, only the second is marked last.
    a_two_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && nres == 2'd2 |-> !tok0.last && tok1.last)
        else $error("last marker wrong on a two-token byte");

    // End of text returns the position to zero, the line to one and the mode to idle.
    a_end_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_text_byte == 8'h00 |=>
            r_state.pos == '0 && r_state.cur_line == LINE_W'(1)
            && r_state.mode == MODE_IDLE)
        else $error("end of text did not rewind the scanner");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for script_source_tokenizer: streams source text in
// byte by byte and checks every token against a scanner model kept in step here.
// Depends on sst_pkg for the scanner modes, token kinds and widths.
module testbench;

    import sst_pkg::*;

    // Characters that have no printable spelling.
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // The cycle limit is ample for a correct run, even when every token meets the
    // slowest receiver pattern and the sender pauses between bursts.
    localparam int CYCLE_LIMIT = 200_000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [7:0]          i_text_byte = CH_NUL;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [KIND_W-1:0]   o_token_kind;
    logic [POS_W-1:0]    o_token_start;
    logic [LEN_W-1:0]    o_token_length;
    logic [LINE_W-1:0]   o_token_line;
    logic                o_run_last;

    script_source_tokenizer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_text_byte    (i_text_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_token_line   (o_token_line),
        .o_run_last     (o_run_last)
    );

    always #1 i_clk = ~i_clk;

    // Tokens that the scanner model has produced and the block has yet to deliver.
    t_token awaited_tokens[$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    int     bytes_sent = 0;

    // Sender burst control. Clearing the flag gives a steady stream with no gaps.
    logic   sender_gaps = 1'b1;
    int     burst_left = 0;

    // Receiver stall pattern: a style held for a random stretch of cycles.
    int     stall_style = 0;
    int     stall_left = 0;

    string keyword_words[6] = '{"let", "if", "else", "while", "return", "fn"};
    string op_words[23] = '{"+", "-", "*", "/", "%", "==", "!=", "<", "<=", ">", ">=",
                            "&&", "||", "!", "=", "(", ")", "{", "}", ",", ";", "&", "|"};

    // ------------------------------------------------------------------
    // Scanner model. A token that may still grow, or that may pair with the
    // next character, is held in tok_* until a later byte settles it.
    // ------------------------------------------------------------------
    t_mode              scan_state;
    logic [POS_W-1:0]   text_pos;
    logic [LINE_W-1:0]  cur_line;
    logic [POS_W-1:0]   tok_start;
    logic [LEN_W-1:0]   tok_len;
    logic [LINE_W-1:0]  tok_line;
    // The first six characters of the identifier being held, newest in the low byte;
    // enough to tell a keyword, since none is longer than six.
    logic [47:0]        word_head;

    function void reset_scanner();
        scan_state = MODE_IDLE;
        text_pos   = '0;
        cur_line   = LINE_W'(1);
        tok_start  = '0;
        tok_len    = '0;
        tok_line   = LINE_W'(1);
        word_head  = '0;
    endfunction

    function logic letter_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function logic numeral_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Position, length and line all stop at their largest value.
    function void advance_pos();
        if (~&text_pos) text_pos = text_pos + 1'b1;
    endfunction

    function void grow_token();
        if (~&tok_len) tok_len = tok_len + 1'b1;
    endfunction

    function void next_line();
        if (~&cur_line) cur_line = cur_line + 1'b1;
    endfunction

    function void open_token(input t_mode m);
        scan_state = m;
        tok_start  = text_pos;
        tok_len    = LEN_W'(1);
        tok_line   = cur_line;
    endfunction

    function void expect_token(input t_kind k, input logic [POS_W-1:0] s,
                               input logic [LEN_W-1:0] l, input logic [LINE_W-1:0] ln);
        t_token t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.line   = ln;
        t.last   = 1'b0;
        awaited_tokens.push_back(t);
    endfunction

    // Kind of the identifier being closed: a keyword only on an exact spelling.
    function t_kind word_kind();
        case (tok_len)
            LEN_W'(2): begin
                if (word_head[15:0] == "if") return KIND_IF;
                if (word_head[15:0] == "fn") return KIND_FN;
            end
            LEN_W'(3): if (word_head[23:0] == "let") return KIND_LET;
            LEN_W'(4): if (word_head[31:0] == "else") return KIND_ELSE;
            LEN_W'(5): if (word_head[39:0] == "while") return KIND_WHILE;
            LEN_W'(6): if (word_head[47:0] == "return") return KIND_RETURN;
            default: ;
        endcase
        return KIND_IDENT;
    endfunction

    // Advances the model by one transferred byte and queues the tokens it closes.
    function void scan_byte(input logic [7:0] c);
        int         first;
        t_mode      was;
        logic       pairable;
        logic       finished;
        logic [7:0] partner;
        t_kind      pair_kind;
        t_kind      lone_kind;
        first     = awaited_tokens.size();
        was       = scan_state;
        pairable  = 1'b0;
        finished  = 1'b0;
        partner   = CH_NUL;
        pair_kind = KIND_END;
        lone_kind = KIND_END;

        case (was)
            MODE_IDENT: begin
                if (letter_byte(c) || numeral_byte(c) || c == "_") begin
                    if (tok_len < LEN_W'(6)) word_head = {word_head[39:0], c};
                    grow_token();
                    advance_pos();
                    finished = 1'b1;
                end else begin
                    expect_token(word_kind(), tok_start, tok_len, tok_line);
                end
            end
            MODE_INT: begin
                if (numeral_byte(c) || c == "_") begin
                    grow_token();
                    advance_pos();
                    finished = 1'b1;
                end else begin
                    expect_token(KIND_INT, tok_start, tok_len, tok_line);
                end
            end
            MODE_EQ: begin
                pairable = 1'b1; partner = "="; pair_kind = KIND_EQEQ; lone_kind = KIND_ASSIGN;
            end
            MODE_BANG: begin
                pairable = 1'b1; partner = "="; pair_kind = KIND_NE; lone_kind = KIND_BANG;
            end
            MODE_LT: begin
                pairable = 1'b1; partner = "="; pair_kind = KIND_LE; lone_kind = KIND_LT;
            end
            MODE_GT: begin
                pairable = 1'b1; partner = "="; pair_kind = KIND_GE; lone_kind = KIND_GT;
            end
            // A lone ampersand or bar is reported as an invalid single character.
            MODE_AMP: begin
                pairable = 1'b1; partner = "&"; pair_kind = KIND_ANDAND; lone_kind = KIND_END;
            end
            MODE_PIPE: begin
                pairable = 1'b1; partner = "|"; pair_kind = KIND_OROR; lone_kind = KIND_END;
            end
            MODE_SLASH: begin
                if (c == "/") begin
                    scan_state = MODE_COMMENT;
                    advance_pos();
                    finished = 1'b1;
                end else begin
                    expect_token(KIND_SLASH, tok_start, LEN_W'(1), tok_line);
                end
            end
            MODE_COMMENT: begin
                // A comment swallows everything up to LF; end of text falls through.
                if (c != CH_NUL) begin
                    if (c == CH_LF) begin
                        next_line();
                        scan_state = MODE_IDLE;
                    end
                    advance_pos();
                    finished = 1'b1;
                end
            end
            default: ;
        endcase

        if (!finished && pairable) begin
            if (c == partner) begin
                expect_token(pair_kind, tok_start, LEN_W'(2), tok_line);
                scan_state = MODE_IDLE;
                advance_pos();
                finished = 1'b1;
            end else begin
                expect_token(lone_kind, tok_start, LEN_W'(1), tok_line);
            end
        end

        // The byte is now scanned afresh from the idle state.
        if (!finished) begin
            scan_state = MODE_IDLE;
            if (c == CH_NUL) begin
                // End of text: a zero-length token, then back to the first line.
                expect_token(KIND_END, text_pos, '0, cur_line);
                reset_scanner();
            end else begin
                if (c == CH_LF) begin
                    next_line();
                end else if (c != " " && c != CH_TAB && c != CH_CR) begin
                    if (letter_byte(c) || c == "_") begin
                        open_token(MODE_IDENT);
                        word_head = {40'b0, c};
                    end else if (numeral_byte(c)) begin
                        open_token(MODE_INT);
                    end else begin
                        case (c)
                            "+": expect_token(KIND_PLUS, text_pos, LEN_W'(1), cur_line);
                            "-": expect_token(KIND_MINUS, text_pos, LEN_W'(1), cur_line);
                            "*": expect_token(KIND_STAR, text_pos, LEN_W'(1), cur_line);
                            "%": expect_token(KIND_PERCENT, text_pos, LEN_W'(1), cur_line);
                            "(": expect_token(KIND_LPAREN, text_pos, LEN_W'(1), cur_line);
                            ")": expect_token(KIND_RPAREN, text_pos, LEN_W'(1), cur_line);
                            "{": expect_token(KIND_LBRACE, text_pos, LEN_W'(1), cur_line);
                            "}": expect_token(KIND_RBRACE, text_pos, LEN_W'(1), cur_line);
                            ",": expect_token(KIND_COMMA, text_pos, LEN_W'(1), cur_line);
                            ";": expect_token(KIND_SEMI, text_pos, LEN_W'(1), cur_line);
                            "/": open_token(MODE_SLASH);
                            "=": open_token(MODE_EQ);
                            "!": open_token(MODE_BANG);
                            "<": open_token(MODE_LT);
                            ">": open_token(MODE_GT);
                            "&": open_token(MODE_AMP);
                            "|": open_token(MODE_PIPE);
                            // Anything unrecognised, the upper half of the byte range too.
                            default: expect_token(KIND_END, text_pos, LEN_W'(1), cur_line);
                        endcase
                    end
                end
                advance_pos();
            end
        end

        // The final token that a byte causes carries the last flag.
        if (awaited_tokens.size() > first)
            awaited_tokens[awaited_tokens.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Valid is raised with the byte and held until the transfer;
    // between bursts it drops for a random number of cycles.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        i_valid     <= 1'b1;
        i_text_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        scan_byte(b);
        bytes_sent++;
        if (sender_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = $urandom_range(0, 40);
            end
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Holds the sender off until every token it has caused has been delivered.
    // At least one edge always passes, so valid is never lowered and raised in one step.
    task automatic wait_all_tokens();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_tokens.size() != 0);
    endtask

    function automatic logic [7:0] random_word_char();
        case ($urandom_range(0, 4))
            0: return "A" + 8'($urandom_range(0, 25));
            1: return "0" + 8'($urandom_range(0, 9));
            2: return "_";
            default: return "a" + 8'($urandom_range(0, 25));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: checks each token transfer against the oldest awaited
    // token and drives ready with a stall pattern of its own.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : token_receiver
        t_token want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_tokens.size() == 0) begin
                $error("token with no expectation: kind %0d start %0d length %0d line %0d",
                       o_token_kind, o_token_start, o_token_length, o_token_line);
                mismatch_count++;
            end else begin
                want = awaited_tokens.pop_front();
                if (o_token_kind !== want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind, o_token_kind);
                    mismatch_count++;
                end
                if (o_token_start !== want.start) begin
                    $error("token_start: expected %0d, got %0d", want.start, o_token_start);
                    mismatch_count++;
                end
                if (o_token_length !== want.length) begin
                    $error("token_length: expected %0d, got %0d", want.length,
                           o_token_length);
                    mismatch_count++;
                end
                if (o_token_line !== want.line) begin
                    $error("token_line: expected %0d, got %0d", want.line, o_token_line);
                    mismatch_count++;
                end
                if (o_run_last !== want.last) begin
                    $error("run_last: expected %0d, got %0d", want.last, o_run_last);
                    mismatch_count++;
                end
            end
        end

        // Styles: always ready, mostly ready, mostly stalled. The last one keeps
        // the output queue full and pushes back on the byte input.
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 2);
            stall_left  = $urandom_range(16, 200);
        end else begin
            stall_left--;
        end
        case (stall_style)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lone ampersand and bar, unknown bytes at both ends of the range, and the
    // end of text arriving inside a comment.
    task automatic test_lone_and_unknown();
        send_text("a&|");
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_text("//");
        send_byte(CH_NUL);
    endtask

    // A short word, an integer with an underscore, tab, CR and LF, a
    // two-character operator followed by a one-character one, then two ends of
    // text in a row so that the second starts from offset 0 on line 1.
    task automatic test_end_of_text();
        send_text("le9=0_");
        send_byte(CH_TAB);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("<=!");
        send_byte(CH_NUL);
        send_byte(CH_NUL);
    endtask

    // Mostly well-formed program text with random content, with near-keywords
    // to exercise the keyword matcher, and a sprinkling of noise and ends of text.
    task automatic test_random_programs();
        int    stop_at;
        int    pick;
        int    n;
        string w;
        stop_at = bytes_sent + 800;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_text(keyword_words[$urandom_range(0, 5)]);
            end else if (pick < 20) begin
                // A keyword cut short or run on.
                w = keyword_words[$urandom_range(0, 5)];
                n = $urandom_range(1, w.len());
                for (int i = 0; i < n; i++) send_byte(w[i]);
                repeat ($urandom_range(0, 2)) send_byte(random_word_char());
            end else if (pick < 30) begin
                send_byte($urandom_range(0, 3) == 0 ? "_" : "a" + 8'($urandom_range(0, 25)));
                repeat ($urandom_range(0, 7)) send_byte(random_word_char());
            end else if (pick < 40) begin
                send_byte("0" + 8'($urandom_range(0, 9)));
                repeat ($urandom_range(0, 5))
                    send_byte($urandom_range(0, 3) == 0 ? "_" : "0" + 8'($urandom_range(0, 9)));
            end else if (pick < 62) begin
                send_text(op_words[$urandom_range(0, 22)]);
            end else if (pick < 82) begin
                case ($urandom_range(0, 3))
                    0: send_byte(CH_TAB);
                    1: send_byte(CH_CR);
                    2: send_byte(CH_LF);
                    default: send_byte(" ");
                endcase
            end else if (pick < 88) begin
                // Comment body of arbitrary bytes, closed by LF or, now and then,
                // by the end of text.
                send_text("//");
                repeat ($urandom_range(0, 10)) begin
                    n = $urandom_range(1, 255);
                    send_byte(8'(n) == CH_LF ? "x" : 8'(n));
                end
                send_byte($urandom_range(0, 4) == 0 ? CH_NUL : CH_LF);
            end else if (pick < 96) begin
                send_byte(8'($urandom_range(1, 255)));
            end else begin
                send_byte(CH_NUL);
            end
        end
    endtask

    initial begin
        reset_scanner();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_lone_and_unknown();
        wait_all_tokens();
        test_end_of_text();
        wait_all_tokens();
        test_random_programs();
        wait_all_tokens();

        // Allow ample time for strays.
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_tokens.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/sst_pkg.sv
hdl/sst_scan.sv
hdl/script_source_tokenizer.sv
dv/testbench.sv
